FILE: rtl/core/lws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_pkg
// shared types and constants of the latency window statistics unit
// ----------------------------------------------------------------------------
package lws_pkg;

  localparam int LINE_W = 4;
  localparam int LAT_W  = 32;
  localparam int CNT_W  = 7;

  // percentile index: ceil(n*k/100) = floor((n*k + 99) * recip >> shift)
  localparam int PCT95       = 95;
  localparam int PCT99       = 99;
  localparam int PCT_BIAS    = 99;
  localparam int PCT_SHIFT   = 24;
  localparam int PCT_RECIP   = 167773;
  localparam int PCT_RECIP_W = 18;

  typedef struct packed {
    logic hist_enable;
  } lws_cfg_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_index;
    logic              is_registered;
    logic              has_activity;
    logic [LAT_W-1:0]  latency_sample;
  } lws_in_t;

  typedef struct packed {
    logic [LINE_W-1:0] out_line;
    logic [CNT_W-1:0]  sample_count;
    logic [LAT_W-1:0]  min_latency;
    logic [LAT_W-1:0]  peak_latency;
    logic [LAT_W-1:0]  avg_latency;
    logic [LAT_W-1:0]  median_latency;
    logic [LAT_W-1:0]  p95_latency;
    logic [LAT_W-1:0]  p99_latency;
  } lws_out_t;

endpackage

FILE: rtl/core/lws_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface lws_cfg_if import lws_pkg::*;;
  logic     valid;
  logic     ready;
  lws_cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/lws_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_in_if
// latency sample channel
// ----------------------------------------------------------------------------
interface lws_in_if import lws_pkg::*;;
  logic    valid;
  logic    ready;
  lws_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/lws_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_out_if
// window statistics channel
// ----------------------------------------------------------------------------
interface lws_out_if import lws_pkg::*;;
  logic     valid;
  logic     ready;
  lws_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/lws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/latency_window_statistics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_window_statistics_unit
// per line sliding window of latencies with min, max, average and percentiles
// ----------------------------------------------------------------------------
// channel  dir  payload    transaction
// cfg      in   lws_cfg_t  history enable write, always ready
// samples  in   lws_in_t   one latency sample for one line
// stats    out  lws_out_t  statistics of the updated window
//
// a kept sample reads and replaces the oldest entry of its line's window,
// works out the percentile indices, then makes one merge pass over the
// sorted window through one ram read port, then runs the average divider
// at one bit a cycle over SW = 32 + clog2(WINDOW_DEPTH+1) bits; samples
// is not ready from acceptance until the result transaction is taken, nor
// during reset
// a dropped sample gives no result; no clearing pass after reset
// ----------------------------------------------------------------------------
module latency_window_statistics_unit import lws_pkg::*; #(
  parameter int NUM_LINES    = 16,
  parameter int WINDOW_DEPTH = 64
) (
  input logic          clk,
  input logic          rst,
  lws_cfg_if.sink      cfg,
  lws_in_if.sink       samples,
  lws_out_if.source    stats
);
  localparam int LW     = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int IW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW     = $clog2(WINDOW_DEPTH + 1);
  localparam int SW     = LAT_W + CW;
  localparam int DW     = $clog2(SW);
  localparam int WDEPTH = NUM_LINES * WINDOW_DEPTH;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int SDEPTH = 2 * WDEPTH;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int XW     = CW + 8;
  localparam int PW     = XW + PCT_RECIP_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_OLD, S_WT_OLD, S_PCT, S_RD, S_PROC, S_TAIL, S_DIV, S_OUT
  } state_t;

  state_t            state;
  logic              hist_en;
  logic [IW-1:0]     wp [NUM_LINES];
  logic [CW-1:0]     fill [NUM_LINES];
  logic              bank [NUM_LINES];
  logic [SW-1:0]     sum_acc [NUM_LINES];

  logic [LINE_W-1:0] line_r;
  logic [LW-1:0]     lidx;
  logic [LAT_W-1:0]  lat_r;
  logic [LAT_W-1:0]  old_r;
  logic [CW-1:0]     n_old;
  logic [CW-1:0]     n_new;
  logic              full_r;
  logic [WAW-1:0]    base_r;
  logic [CW-1:0]     i_r;
  logic [CW-1:0]     o_r;
  logic              removed;
  logic              inserted;
  logic [PW-1:0]     prod;
  logic [CW-1:0]     p95i;
  logic [CW-1:0]     p99i;
  logic [LAT_W-1:0]  minr, maxr, medr, p95r, p99r;
  logic [SW-1:0]     quo;
  logic [CW-1:0]     rem;
  logic [DW-1:0]     dcnt;

  logic [LAT_W-1:0]  win_rdata;
  logic [LAT_W-1:0]  srt_rdata;
  logic [WAW-1:0]    win_addr;
  logic [SAW-1:0]    srt_raddr;
  logic [SAW-1:0]    srt_waddr;
  logic              sw_en;
  logic [LAT_W-1:0]  sw_data;
  logic              do_skip;
  logic              do_ins;
  logic              take;
  logic [LW-1:0]     lsel;
  logic [CW-1:0]     fsel;
  logic [XW-1:0]     x95;
  logic [XW-1:0]     x99;
  logic [CW-1:0]     pidx;
  logic [CW-1:0]     pclamp;
  logic [SW-1:0]     sum_new;
  logic [CW:0]       rs;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == S_IDLE) && !rst;
  assign stats.valid   = (state == S_OUT) && !rst;

  assign stats.data.out_line       = line_r;
  assign stats.data.sample_count   = CNT_W'(n_new);
  assign stats.data.min_latency    = minr;
  assign stats.data.peak_latency   = maxr;
  assign stats.data.avg_latency    = quo[LAT_W-1:0];
  assign stats.data.median_latency = medr;
  assign stats.data.p95_latency    = p95r;
  assign stats.data.p99_latency    = p99r;

  assign lsel = LW'(samples.data.line_index);
  assign fsel = fill[lsel];
  assign take = hist_en && samples.data.is_registered && samples.data.has_activity &&
                (int'(samples.data.line_index) < NUM_LINES);

  assign x95    = XW'(n_new) * XW'(PCT95) + XW'(PCT_BIAS);
  assign x99    = XW'(n_new) * XW'(PCT99) + XW'(PCT_BIAS);
  assign pidx   = CW'(prod >> PCT_SHIFT);
  assign pclamp = (pidx >= n_new) ? n_new - CW'(1) : pidx;

  assign sum_new = sum_acc[lidx] - (full_r ? SW'(win_rdata) : SW'(0)) + SW'(lat_r);
  assign rs      = {rem, quo[SW-1]};

  assign win_addr  = base_r + WAW'(wp[lidx]);
  assign srt_raddr = (bank[lidx] ? SAW'(WDEPTH) : SAW'(0)) + SAW'(base_r) + SAW'(i_r);
  assign srt_waddr = (bank[lidx] ? SAW'(0) : SAW'(WDEPTH)) + SAW'(base_r) + SAW'(o_r);

  lws_ram #(.WIDTH(LAT_W), .DEPTH(WDEPTH)) u_window (
    .clk   (clk),
    .we    (state == S_WT_OLD),
    .waddr (win_addr),
    .wdata (lat_r),
    .raddr (win_addr),
    .rdata (win_rdata)
  );

  lws_ram #(.WIDTH(LAT_W), .DEPTH(SDEPTH)) u_sorted (
    .clk   (clk),
    .we    (sw_en),
    .waddr (srt_waddr),
    .wdata (sw_data),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

  // merge step: drop one copy of the evicted sample, insert the new one
  always_comb begin
    do_skip = 1'b0;
    do_ins  = 1'b0;
    sw_en   = 1'b0;
    sw_data = srt_rdata;
    if (state == S_PROC) begin
      if (full_r && !removed && (srt_rdata == old_r)) begin
        do_skip = 1'b1;
      end else if (!inserted && (lat_r < srt_rdata)) begin
        do_ins  = 1'b1;
        sw_en   = 1'b1;
        sw_data = lat_r;
      end else begin
        sw_en = 1'b1;
      end
    end else if ((state == S_TAIL) && !inserted) begin
      sw_en   = 1'b1;
      sw_data = lat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      hist_en <= 1'b0;
      for (int k = 0; k < NUM_LINES; k++) begin
        wp[k]      <= '0;
        fill[k]    <= '0;
        bank[k]    <= 1'b0;
        sum_acc[k] <= '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        hist_en <= cfg.data.hist_enable;
      end
      if (sw_en) begin
        o_r <= o_r + CW'(1);
        if (o_r == '0) minr <= sw_data;
        if (o_r == n_new - CW'(1)) maxr <= sw_data;
        if (o_r == (n_new >> 1)) medr <= sw_data;
        if (o_r == p95i) p95r <= sw_data;
        if (o_r == p99i) p99r <= sw_data;
      end
      unique case (state)
        S_IDLE: begin
          if (samples.valid && take) begin
            line_r <= samples.data.line_index;
            lidx   <= lsel;
            lat_r  <= samples.data.latency_sample;
            n_old  <= fsel;
            full_r <= (fsel == CW'(WINDOW_DEPTH));
            n_new  <= (fsel == CW'(WINDOW_DEPTH)) ? fsel : fsel + CW'(1);
            base_r <= WAW'(int'(lsel) * WINDOW_DEPTH);
            state  <= S_RD_OLD;
          end
        end
        S_RD_OLD: begin
          prod  <= PW'(x95) * PW'(PCT_RECIP);
          state <= S_WT_OLD;
        end
        S_WT_OLD: begin
          old_r        <= win_rdata;
          wp[lidx]     <= (wp[lidx] == IW'(WINDOW_DEPTH - 1)) ? '0 : wp[lidx] + IW'(1);
          fill[lidx]   <= n_new;
          sum_acc[lidx] <= sum_new;
          quo          <= sum_new;
          p95i         <= pclamp;
          prod         <= PW'(x99) * PW'(PCT_RECIP);
          state        <= S_PCT;
        end
        S_PCT: begin
          p99i     <= pclamp;
          i_r      <= '0;
          o_r      <= '0;
          removed  <= 1'b0;
          inserted <= 1'b0;
          state    <= (n_old == '0) ? S_TAIL : S_RD;
        end
        S_RD: begin
          state <= S_PROC;
        end
        S_PROC: begin
          if (do_skip) removed <= 1'b1;
          if (do_ins) begin
            inserted <= 1'b1;
          end else if (i_r + CW'(1) == n_old) begin
            state <= S_TAIL;
          end else begin
            i_r   <= i_r + CW'(1);
            state <= S_RD;
          end
        end
        S_TAIL: begin
          bank[lidx] <= ~bank[lidx];
          rem        <= '0;
          dcnt       <= '0;
          state      <= S_DIV;
        end
        S_DIV: begin
          if (rs >= {1'b0, n_new}) begin
            rem <= CW'(rs - {1'b0, n_new});
            quo <= {quo[SW-2:0], 1'b1};
          end else begin
            rem <= CW'(rs);
            quo <= {quo[SW-2:0], 1'b0};
          end
          dcnt <= dcnt + DW'(1);
          if (dcnt == DW'(SW - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (stats.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    stats.valid |-> !samples.ready)
    else $error("sample accepted while a result is pending");

  a_pct_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ((p95i < n_new) && (p99i < n_new) && (p95i <= p99i)))
    else $error("percentile index out of window");

  a_merge_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && $past(state == S_TAIL) |-> (o_r == n_new))
    else $error("merge pass wrote a wrong number of entries");

  a_order: assert property (@(posedge clk) disable iff (rst)
    stats.valid |-> ((minr <= medr) && (medr <= p95r) && (p95r <= p99r) &&
                     (p99r <= maxr)))
    else $error("statistics out of order");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// regression of the latency window statistics unit
// ----------------------------------------------------------------------------
// latency samples are offered with random gaps and random result stalls. A
// predictor keeps its own per line windows, write pointers and fill counts,
// works out the statistics of each kept sample, and every result transaction
// is compared with the oldest expectation. The history enable
// register is toggled between phases, once the block has gone idle.
// ----------------------------------------------------------------------------
module tb_top import lws_pkg::*; ;

  localparam int NLINES = 16;
  localparam int DEPTH  = 64;
  localparam int LIMIT  = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  lws_cfg_if cfg_ch ();
  lws_in_if  smp_ch ();
  lws_out_if st_ch ();

  latency_window_statistics_unit #(.NUM_LINES(NLINES), .WINDOW_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .samples(smp_ch.sink), .stats(st_ch.source)
  );

  // predictor state
  logic [LAT_W-1:0] win_mem [NLINES][DEPTH];
  int unsigned      wr_ptr [NLINES];
  int unsigned      fill [NLINES];
  logic             hist_en;

  lws_in_t  pending_samples [$];
  lws_out_t expected_stats [$];

  int  mismatches = 0;
  bit  idle_off = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;

  function automatic int unsigned pct_pos(int unsigned n, int unsigned k);
    int unsigned p;
    p = (n * k + 99) / 100;
    if (p >= n) begin
      p = n - 1;
    end
    return p;
  endfunction

  function automatic void predict_window(lws_in_t s);
    logic [LAT_W-1:0] srt [$];
    longint unsigned  total;
    int unsigned      ln;
    int unsigned      n;
    lws_out_t         r;
    ln = s.line_index;
    if (!hist_en || !s.is_registered || !s.has_activity || ln >= NLINES) begin
      return;
    end
    win_mem[ln][wr_ptr[ln]] = s.latency_sample;
    wr_ptr[ln] = (wr_ptr[ln] + 1) % DEPTH;
    if (fill[ln] < DEPTH) begin
      fill[ln]++;
    end
    n = fill[ln];
    total = 0;
    for (int i = 0; i < n; i++) begin
      srt.push_back(win_mem[ln][i]);
      total += win_mem[ln][i];
    end
    srt.sort();
    r.out_line = ln[LINE_W-1:0];
    r.sample_count = n[CNT_W-1:0];
    r.min_latency = srt[0];
    r.peak_latency = srt[n-1];
    r.avg_latency = LAT_W'(total / n);
    r.median_latency = srt[n/2];
    r.p95_latency = srt[pct_pos(n, PCT95)];
    r.p99_latency = srt[pct_pos(n, PCT99)];
    expected_stats.push_back(r);
  endfunction

  // sample driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      smp_ch.valid <= 1'b0;
      smp_ch.data <= '0;
    end else begin
      if (smp_ch.valid && smp_ch.ready) begin
        predict_window(smp_ch.data);
      end
      if (!smp_ch.valid || smp_ch.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          smp_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          smp_ch.data <= pending_samples.pop_front();
          smp_ch.valid <= 1'b1;
          if (!idle_off && $urandom_range(0, 9) == 0) begin
            src_gap <= $urandom_range(1, 14);
          end
        end else begin
          smp_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= 2000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // stats monitor
  int snk_gap = 0;
  always @(posedge clk) begin
    lws_out_t e;
    if (rst) begin
      st_ch.ready <= 1'b0;
    end else begin
      if (st_ch.valid && st_ch.ready) begin
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected stats transaction %p", st_ch.data);
          end
        end else begin
          e = expected_stats.pop_front();
          if (e !== st_ch.data) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("stats mismatch expected %p actual %p", e, st_ch.data);
            end
          end
        end
      end
      if (hold_left > 0 || hold_req) begin
        st_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        st_ch.ready <= 1'b0;
      end else begin
        st_ch.ready <= 1'b1;
        if (!idle_off && $urandom_range(0, 9) == 0) begin
          snk_gap <= $urandom_range(1, 14);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("latency_window_statistics_unit regression: fail");
      $finish;
    end
  end

  function automatic lws_in_t rand_sample(bit valid_seq);
    lws_in_t s;
    s.line_index = LINE_W'($urandom_range(0, 15));
    s.is_registered = valid_seq ? 1'b1 : 1'($urandom);
    s.has_activity = valid_seq ? 1'b1 : 1'($urandom);
    case ($urandom_range(0, 5))
      0: s.latency_sample = '1;
      1: s.latency_sample = '0;
      2: s.latency_sample = $urandom_range(0, 20);
      default: s.latency_sample = $urandom;
    endcase
    return s;
  endfunction

  task automatic write_enable(bit v);
    @(posedge clk);
    cfg_ch.data.hist_enable <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    hist_en = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_samples.size() > 0 || smp_ch.valid || expected_stats.size() > 0) begin
      @(posedge clk);
    end
    repeat (400) @(posedge clk);
  endtask

  function automatic lws_in_t mk(int ln, bit rg, bit ac, logic [31:0] v);
    lws_in_t s;
    s.line_index = LINE_W'(ln);
    s.is_registered = rg;
    s.has_activity = ac;
    s.latency_sample = v;
    return s;
  endfunction

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    hist_en = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // history disabled after reset: all ignored
    pending_samples.push_back(mk(3, 1, 1, 32'd7));
    pending_samples.push_back(mk(15, 1, 1, '1));
    drain_all();
    write_enable(1'b1);
    // directed
    pending_samples.push_back(mk(0, 1, 1, 32'd0));
    pending_samples.push_back(mk(0, 1, 1, '1));
    pending_samples.push_back(mk(0, 1, 1, '1));
    pending_samples.push_back(mk(0, 1, 1, 32'h5555_aaaa));
    pending_samples.push_back(mk(15, 1, 1, 32'haaaa_5555));
    pending_samples.push_back(mk(1, 0, 1, 32'd9));
    pending_samples.push_back(mk(1, 1, 0, 32'd9));
    pending_samples.push_back(mk(1, 0, 0, 32'd9));
    pending_samples.push_back(mk(1, 1, 1, 32'd9));
    // fill line 2 past the window to wrap
    for (int i = 0; i < DEPTH + 5; i++) begin
      pending_samples.push_back(mk(2, 1, 1, (i * 37) % 101));
    end
    drain_all();
    write_enable(1'b0);
    pending_samples.push_back(mk(2, 1, 1, 32'd3));
    drain_all();
    write_enable(1'b1);

    // receiver holds off while sender keeps offering
    for (int i = 0; i < 40; i++) begin
      pending_samples.push_back(rand_sample(1'b1));
    end
    hold_req = 1'b1;
    repeat (5) @(posedge clk);
    hold_req = 1'b0;
    drain_all();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 230; i++) begin
        pending_samples.push_back(rand_sample($urandom_range(0, 4) != 0));
      end
      if (ph == 5) begin
        idle_off = 1'b1;
      end
      drain_all();
      if (ph == 2) begin
        write_enable(1'b0);
        for (int i = 0; i < 20; i++) begin
          pending_samples.push_back(rand_sample(1'b1));
        end
        drain_all();
        write_enable(1'b1);
      end
    end

    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("latency_window_statistics_unit regression: pass");
    end else begin
      $display("latency_window_statistics_unit regression: fail");
    end
    $finish;
  end
endmodule
